FILE: rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Shared widths, operation codes and status codes for the positional list core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

   // Default list capacity
   localparam int DEPTH_DEFAULT = 32;

   // Field widths
   localparam int FUNC_W   = 2;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 6;

   // Stream widths
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = FUNC_W;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_FIELD_W = STATUS_W + DATA_W + INDEX_W + COUNT_W;

   // Operation codes carried on req_tuser
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/pli_ram.sv
// ----------------------------------------------------------------------------
// Positional list storage
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_ram #(
   parameter int DEPTH = pli_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                        clock,
   input  wire                        wr_en,
   input  wire  [AW-1:0]              wr_addr,
   input  wire  [pli_pkg::DATA_W-1:0] wr_data,
   input  wire                        rd_en,
   input  wire  [AW-1:0]              rd_addr,
   output logic [pli_pkg::DATA_W-1:0] rd_data
);
   import pli_pkg::*;

   logic [DATA_W-1:0] cells_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
   end

   // Read into the output register; hold it while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/positional_list_insert_delete_core.sv
// Insert and delete: the entries that move are read and written back one place up or
//   down, then the value is placed or the list shrinks; a rejected item skips the shift.
// Dump: entries are read ahead and registered in order, one element per cycle while
//   rsp_tready stays high; an empty list gives a single result.
// Throughput: one item at a time; the next item is taken once the last result
//   is in the output register. Reset clears the count; storage is not cleared.
// ----------------------------------------------------------------------------
// Positional list core
// Ordered list of signed values in a RAM with insert, delete and dump.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete_core #(
   parameter int DEPTH = pli_pkg::DEPTH_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   // Request channel
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [pli_pkg::REQ_TDATA_W-1:0] req_tdata,  // [5:0] position, [37:6] value
   input  wire  [pli_pkg::REQ_TUSER_W-1:0] req_tuser,  // [1:0] func
   // Response channel
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [pli_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [1:0] status, [33:2] element,
                                                       // [39:34] element_index,
                                                       // [45:40] count
   output logic                            rsp_tlast
);
   import pli_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   // Sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MOVE = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                ins_ff, ins_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   val_ff, val_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [AW-1:0]       src_ff, src_in;
   logic [CW-1:0]       left_ff, left_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [AW-1:0]       rd_addr_ff, rd_addr_in;
   logic [CW-1:0]       dump_idx_ff, dump_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_elem_ff, rsp_elem_in;
   logic [INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff, rsp_last_in;
   logic                load;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [DATA_W-1:0]   rd_data;

   logic                req_fire;
   logic [FUNC_W-1:0]   req_func;
   logic [POS_W-1:0]    req_pos;
   logic [DATA_W-1:0]   req_value;
   logic [CMPW-1:0]     pos_ext;
   logic [CMPW-1:0]     fill_ext;
   logic [CMPW-1:0]     idx_ext;
   logic [CW-1:0]       fill_m1;
   logic                pos_zero;
   logic                ins_bad;
   logic                del_bad;
   logic                list_full;
   logic                list_empty;
   logic                out_free;
   logic                can_load;
   logic                dump_last;

   // Storage
   pli_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Unpack the request beat
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_func   = req_tuser[FUNC_W-1:0];
   assign req_pos    = req_tdata[POS_W-1:0];
   assign req_value  = req_tdata[POS_W+DATA_W-1:POS_W];

   // Range checks against the current fill
   assign pos_ext    = CMPW'(req_pos);
   assign fill_ext   = CMPW'(fill_ff);
   assign fill_m1    = fill_ff - CW'(1);
   assign pos_zero   = (req_pos == '0);
   assign ins_bad    = pos_zero || (pos_ext > (fill_ext + CMPW'(1)));
   assign del_bad    = pos_zero || (pos_ext > fill_ext);
   assign list_full  = (fill_ff == CW'(DEPTH));
   assign list_empty = (fill_ff == '0);

   // Dump bookkeeping for the entry in the RAM read register
   assign idx_ext   = CMPW'(rd_addr_ff) + CMPW'(1);
   assign dump_last = (idx_ext == fill_ext);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign can_load  = rd_valid_ff && out_free;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      ins_in        = ins_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      st_in         = st_ff;
      src_in        = src_ff;
      left_in       = left_ff;
      rd_valid_in   = rd_valid_ff;
      rd_addr_in    = rd_addr_ff;
      dump_idx_in   = dump_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = src_ff;
      load          = 1'b0;
      rsp_status_in = ST_OK;
      rsp_elem_in   = '0;
      rsp_idx_in    = '0;
      rsp_last_in   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pos_in = req_pos;
               val_in = req_value;
               case (req_func)
                  FUNC_INSERT: begin
                     if (ins_bad) begin
                        st_in    = ST_BADPOS;
                        state_in = S_RESP;
                     end else if (list_full) begin
                        st_in    = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        ins_in   = 1'b1;
                        src_in   = fill_m1[AW-1:0];
                        left_in  = fill_ff + CW'(1) - pos_ext[CW-1:0];
                        state_in = S_MOVE;
                     end
                  end
                  FUNC_DELETE: begin
                     if (list_empty) begin
                        st_in    = ST_EMPTY;
                        state_in = S_RESP;
                     end else if (del_bad) begin
                        st_in    = ST_BADPOS;
                        state_in = S_RESP;
                     end else begin
                        ins_in   = 1'b0;
                        src_in   = pos_ext[AW-1:0];
                        left_in  = fill_ff - pos_ext[CW-1:0];
                        state_in = S_MOVE;
                     end
                  end
                  FUNC_DUMP: begin
                     if (list_empty) begin
                        st_in    = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        dump_idx_in = '0;
                        state_in    = S_DUMP;
                     end
                  end
                  default: begin
                     // unused code: drop the beat
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_MOVE: begin
            // write back the entry read last cycle, one place up or down
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = ins_ff ? (rd_addr_ff + AW'(1)) : (rd_addr_ff - AW'(1));
               wr_data = rd_data;
            end
            if (left_ff != '0) begin
               // issue the next source read
               rd_en       = 1'b1;
               rd_addr     = src_ff;
               rd_addr_in  = src_ff;
               rd_valid_in = 1'b1;
               src_in      = ins_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
               left_in     = left_ff - CW'(1);
            end else begin
               rd_valid_in = 1'b0;
               if (!rd_valid_ff) begin
                  // shift done: place the new value or shrink the list
                  if (ins_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(pos_ff - POS_W'(1));
                     wr_data = val_ff;
                     fill_in = fill_ff + CW'(1);
                  end else begin
                     fill_in = fill_ff - CW'(1);
                  end
                  st_in    = ST_OK;
                  state_in = S_RESP;
               end
            end
         end

         S_DUMP: begin
            // move the read entry into the output register
            if (can_load) begin
               load          = 1'b1;
               rsp_status_in = ST_OK;
               rsp_elem_in   = rd_data;
               rsp_idx_in    = idx_ext[INDEX_W-1:0];
               rsp_last_in   = dump_last;
               rd_valid_in   = 1'b0;
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
            // read ahead while the read register is free or draining
            if ((dump_idx_ff != fill_ff) && (!rd_valid_ff || can_load)) begin
               rd_en       = 1'b1;
               rd_addr     = dump_idx_ff[AW-1:0];
               rd_addr_in  = dump_idx_ff[AW-1:0];
               rd_valid_in = 1'b1;
               dump_idx_in = dump_idx_ff + CW'(1);
            end
         end

         S_RESP: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = st_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold a result until the consumer takes it
   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_tready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Operation payload
   always_ff @(posedge clock) begin
      ins_ff      <= ins_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      st_ff       <= st_in;
      src_ff      <= src_in;
      left_ff     <= left_in;
      rd_addr_ff  <= rd_addr_in;
      dump_idx_ff <= dump_idx_in;
   end

   // Output register; count is the fill after the operation
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_elem_ff   <= rsp_elem_in;
         rsp_idx_ff    <= rsp_idx_in;
         rsp_count_ff  <= fill_ext[COUNT_W-1:0];
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}},
                        rsp_count_ff, rsp_idx_ff, rsp_elem_ff, rsp_status_ff};

`ifndef NO_ASSERTIONS
   // The list never holds more than its capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill exceeds capacity");

   // A dump leaves the count untouched
   a_dump_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |=> $stable(fill_ff))
      else $error("fill changed during dump");

   // The RAM is written only while shifting
   a_wr_move: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DUMP || state_ff == S_RESP) |-> !wr_en)
      else $error("RAM write outside move");

   // No read is left in flight when a new item may enter
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !rd_valid_ff)
      else $error("stale read in idle");
`endif

endmodule

`default_nettype wire

FILE: sim/positional_list_insert_delete_core_test.sv
// ----------------------------------------------------------------------------
// Positional list core testbench
// Drives insert, delete and dump requests on the request stream and checks
// every response beat against a list model kept beside the core. A short
// table covers the edges and error codes. Random requests follow: first they
// grow the list toward full, then they drain it toward empty. Both streams
// stall at random, at rates set in three phases; the last phase has no stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_insert_delete_core_test;

   import pli_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   // func code 3 has no meaning; the core drops it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_OPS  = 96;
   localparam int DIRECTED_OPS = 24;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   element;
      logic [INDEX_W-1:0]  element_index;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } list_rsp_type;

   // One table row; a fixed row carries a status and count to expect directly
   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [POS_W-1:0]    position;
      logic [DATA_W-1:0]   value;
      logic                fixed;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } list_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   // List model state
   logic [DATA_W-1:0] shadow_cells [DEPTH];
   int                shadow_fill = 0;
   list_rsp_type      expected_rsp_q [$];

   int           sender_idle_pct = 11;
   int           receiver_idle_pct = 54;
   bit           mismatch_seen = 1'b0;
   int           quiet_cycles = 0;
   list_cmd_type directed_cmds [DIRECTED_OPS];

   positional_list_insert_delete_core #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // Apply one request to the list model; queue its responses when asked
   function automatic void apply_list_op(input logic [FUNC_W-1:0] func,
                                         input logic [POS_W-1:0] position,
                                         input logic [DATA_W-1:0] value,
                                         input bit record);
      list_rsp_type rsp;
      int           pos;
      pos = position;
      rsp = '{status: ST_OK, element: '0, element_index: '0,
              count: shadow_fill[COUNT_W-1:0], last: 1'b1};
      case (func)
         FUNC_INSERT: begin
            if (pos == 0 || pos > shadow_fill + 1) begin
               rsp.status = ST_BADPOS;
            end else if (shadow_fill >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               for (int i = shadow_fill; i >= pos; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[pos-1] = value;
               shadow_fill++;
               rsp.count = shadow_fill[COUNT_W-1:0];
            end
            if (record) expected_rsp_q.push_back(rsp);
         end
         FUNC_DELETE: begin
            if (shadow_fill == 0) begin
               rsp.status = ST_EMPTY;
            end else if (pos == 0 || pos > shadow_fill) begin
               rsp.status = ST_BADPOS;
            end else begin
               for (int i = pos - 1; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i+1];
               shadow_fill--;
               rsp.count = shadow_fill[COUNT_W-1:0];
            end
            if (record) expected_rsp_q.push_back(rsp);
         end
         FUNC_DUMP: begin
            if (shadow_fill == 0) begin
               rsp.status = ST_EMPTY;
               if (record) expected_rsp_q.push_back(rsp);
            end else begin
               for (int i = 0; i < shadow_fill; i++) begin
                  rsp.element = shadow_cells[i];
                  rsp.element_index = INDEX_W'(i + 1);
                  rsp.last = (i + 1 == shadow_fill);
                  if (record) expected_rsp_q.push_back(rsp);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Present one request beat, hold it until taken, then update the model
   task automatic send_list_op(input list_cmd_type cmd);
      list_rsp_type fixed_rsp;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, cmd.value, cmd.position};
      req_tuser  <= cmd.func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_list_op(cmd.func, cmd.position, cmd.value, !cmd.fixed);
      if (cmd.fixed) begin
         fixed_rsp = '{status: cmd.status, element: '0, element_index: '0,
                       count: cmd.count, last: 1'b1};
         expected_rsp_q.push_back(fixed_rsp);
      end
   endtask

   function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_val,
                                       input logic [DATA_W-1:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
         mismatch_seen = 1'b1;
      end
   endfunction

   // Take response beats with random back-pressure and check each one
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %0h last %0b",
                     $time, rsp_tdata, rsp_tlast);
            mismatch_seen = 1'b1;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("status", DATA_W'(want.status), DATA_W'(rsp_tdata[1:0]));
            check_field("element", want.element, rsp_tdata[33:2]);
            check_field("element_index", DATA_W'(want.element_index), DATA_W'(rsp_tdata[39:34]));
            check_field("count", DATA_W'(want.count), DATA_W'(rsp_tdata[45:40]));
            check_field("last", DATA_W'(want.last), DATA_W'(rsp_tlast));
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Stop a hung run: count cycles in which neither stream moves a beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("[positional_list_insert_delete_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      list_cmd_type cmd;
      int           pick;
      directed_cmds = '{
         // empty list: dump, delete, inserts at bad positions
         '{FUNC_DUMP,    6'd0,  32'h00000000, 1'b1, ST_EMPTY,  6'd0},
         '{FUNC_DELETE,  6'd1,  32'h00000000, 1'b1, ST_EMPTY,  6'd0},
         '{FUNC_INSERT,  6'd0,  32'h00000005, 1'b1, ST_BADPOS, 6'd0},
         '{FUNC_INSERT,  6'd2,  32'h00000005, 1'b1, ST_BADPOS, 6'd0},
         '{FUNC_INSERT,  6'd63, 32'h00000005, 1'b1, ST_BADPOS, 6'd0},
         // value extremes at head, tail and middle
         '{FUNC_INSERT,  6'd1,  32'h7FFFFFFF, 1'b1, ST_OK,     6'd1},
         '{FUNC_INSERT,  6'd1,  32'h80000000, 1'b1, ST_OK,     6'd2},
         '{FUNC_INSERT,  6'd3,  32'hFFFFFFFF, 1'b1, ST_OK,     6'd3},
         '{FUNC_INSERT,  6'd2,  32'h00000000, 1'b1, ST_OK,     6'd4},
         '{FUNC_DUMP,    6'd0,  32'h00000000, 1'b0, ST_OK,     6'd0},
         // deletes out of range, unused code, insert past the end
         '{FUNC_DELETE,  6'd0,  32'h00000000, 1'b1, ST_BADPOS, 6'd4},
         '{FUNC_DELETE,  6'd5,  32'h00000000, 1'b1, ST_BADPOS, 6'd4},
         '{FUNC_DELETE,  6'd63, 32'hFFFFFFFF, 1'b1, ST_BADPOS, 6'd4},
         '{FUNC_UNUSED,  6'd63, 32'hFFFFFFFF, 1'b0, ST_OK,     6'd0},
         '{FUNC_INSERT,  6'd6,  32'h12345678, 1'b1, ST_BADPOS, 6'd4},
         '{FUNC_INSERT,  6'd5,  32'h5A5A5A5A, 1'b0, ST_OK,     6'd0},
         // deletes at tail, head and middle
         '{FUNC_DELETE,  6'd5,  32'h00000000, 1'b0, ST_OK,     6'd0},
         '{FUNC_DELETE,  6'd1,  32'h00000000, 1'b0, ST_OK,     6'd0},
         '{FUNC_DUMP,    6'd0,  32'h00000000, 1'b0, ST_OK,     6'd0},
         '{FUNC_DELETE,  6'd2,  32'h00000000, 1'b0, ST_OK,     6'd0},
         '{FUNC_DUMP,    6'd0,  32'h00000000, 1'b0, ST_OK,     6'd0},
         '{FUNC_DELETE,  6'd1,  32'h00000000, 1'b0, ST_OK,     6'd0},
         '{FUNC_DELETE,  6'd1,  32'h00000000, 1'b0, ST_OK,     6'd0},
         '{FUNC_DUMP,    6'd0,  32'h00000000, 1'b1, ST_EMPTY,  6'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cmds[k]) send_list_op(directed_cmds[k]);

      // Random part: mostly inserts to grow the list toward full, then mostly deletes to drain it
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == 32) begin
            sender_idle_pct = 54;
            receiver_idle_pct = 11;
         end else if (n == 64) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         pick = $urandom_range(99);
         if (n < 44) begin
            cmd.func = (pick < 85) ? FUNC_INSERT : (pick < 88) ? FUNC_DELETE :
                       (pick < 97) ? FUNC_DUMP : FUNC_UNUSED;
         end else begin
            cmd.func = (pick < 85) ? FUNC_DELETE : (pick < 90) ? FUNC_INSERT :
                       (pick < 97) ? FUNC_DUMP : FUNC_UNUSED;
         end
         // mostly legal positions, now and then any six-bit value
         if ($urandom_range(9) == 0) begin
            cmd.position = POS_W'($urandom_range(63));
         end else if (cmd.func == FUNC_INSERT) begin
            cmd.position = POS_W'($urandom_range(shadow_fill + 1, 1));
         end else begin
            cmd.position = POS_W'($urandom_range((shadow_fill > 0) ? shadow_fill : 1, 1));
         end
         cmd.value = $urandom;
         cmd.fixed = 1'b0;
         cmd.status = ST_OK;
         cmd.count = '0;
         send_list_op(cmd);
      end
      req_tvalid <= 1'b0;

      // Drain outstanding responses, then allow for any late stray beat
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!mismatch_seen) begin
         $display("[positional_list_insert_delete_core] OK");
      end else begin
         $display("[positional_list_insert_delete_core] ERROR");
      end
      $finish;
   end

endmodule
